### rtl/rlm_pkg.sv
// ----------------------------------------------------------------------------
// rlm_pkg: shared types and constants of the RGB LED matrix PWM scanner
// Holds field widths, the command codes, the store request bundle and the
// constants used by the hue conversion.
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int unsigned RowCountDef = 8;
  localparam int unsigned ColCountDef = 8;

  localparam int unsigned LevelW = 8;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned AddrW  = 1 + 2 * IdxW;
  localparam int unsigned PixW   = 3 * LevelW;
  localparam int unsigned HueW   = 9;
  localparam int unsigned RemW   = 6;

  localparam logic [LevelW-1:0] LevelsReset = 8'd255;

  // Hue arithmetic: degrees in a full turn and in one sector.
  localparam logic [HueW-1:0] HueTurn   = 9'd360;
  localparam logic [RemW-1:0] HueSector = 6'd60;

  // floor(x / 60) == floor((x >> 2) * HueRecip >> 16) for x below 15360.
  localparam logic [12:0] HueRecip = 13'd4370;

  typedef enum logic [1:0] {
    MODE_RGB  = 2'd0,
    MODE_HUE  = 2'd1,
    MODE_SWAP = 2'd2,
    MODE_SCAN = 2'd3
  } rlm_mode_e;

  // One access to the pixel store: either a write or a read, never both.
  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  wdata;
  } rlm_store_req_t;

endpackage

### rtl/rlm_pixel_store.sv
// ----------------------------------------------------------------------------
// rlm_pixel_store: single-port pixel memory with per-entry valid bits
// One read or one write per cycle, read data registered. Entries never
// written since reset read as zero.
// ----------------------------------------------------------------------------
module rlm_pixel_store
  import rlm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rlm_store_req_t       req_i,
  output logic [PixW-1:0]      rdata_o
);

  localparam int unsigned Depth = 2 ** AddrW;

  logic [PixW-1:0] mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [PixW-1:0] rdata_q;
  logic rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end else if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.addr] <= 1'b1;
      end else if (req_i.re) begin
        rvalid_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

### rtl/rlm_hue_conv.sv
// ----------------------------------------------------------------------------
// rlm_hue_conv: hue to full-saturation RGB conversion
// Three register stages: sector split, level products, scaling by 1/60
// through a reciprocal multiply with the sector's channel selection.
// ----------------------------------------------------------------------------
module rlm_hue_conv
  import rlm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [HueW-1:0]   hue_i,
  input  logic [LevelW-1:0] levels_i,
  output logic              done_o,
  output logic [PixW-1:0]   rgb_o
);

  logic [2:0] vld_q;

  logic [HueW-1:0] h;
  logic [2:0]      sector_d, sector1_q, sector2_q;
  logic [RemW-1:0] rem_d, rem_q;
  logic [13:0]     prod_t_d, prod_q_d, prod_t_q, prod_q_q;
  logic [24:0]     mul_t, mul_q;
  logic [LevelW-1:0] t_val, q_val, full_q;
  logic [PixW-1:0] rgb_d, rgb_q;

  // Stage 1: reduce to 0..359 and split into sector and remainder.
  always_comb begin
    h = (hue_i >= HueTurn) ? HueW'(hue_i - HueTurn) : hue_i;
    if (h >= 9'd300) begin
      sector_d = 3'd5;
      rem_d    = RemW'(h - 9'd300);
    end else if (h >= 9'd240) begin
      sector_d = 3'd4;
      rem_d    = RemW'(h - 9'd240);
    end else if (h >= 9'd180) begin
      sector_d = 3'd3;
      rem_d    = RemW'(h - 9'd180);
    end else if (h >= 9'd120) begin
      sector_d = 3'd2;
      rem_d    = RemW'(h - 9'd120);
    end else if (h >= 9'd60) begin
      sector_d = 3'd1;
      rem_d    = RemW'(h - 9'd60);
    end else begin
      sector_d = 3'd0;
      rem_d    = RemW'(h);
    end
  end

  // Stage 2: rising and falling products against the full-scale level.
  assign prod_t_d = 14'(rem_q) * 14'(levels_i);
  assign prod_q_d = 14'(RemW'(HueSector - rem_q)) * 14'(levels_i);

  // Stage 3: divide by 60 and place the channels by sector.
  assign mul_t = 25'(prod_t_q[13:2]) * 25'(HueRecip);
  assign mul_q = 25'(prod_q_q[13:2]) * 25'(HueRecip);
  assign t_val = mul_t[23:16];
  assign q_val = mul_q[23:16];

  always_comb begin
    case (sector2_q)
      3'd0:    rgb_d = {full_q, t_val, 8'd0};
      3'd1:    rgb_d = {q_val, full_q, 8'd0};
      3'd2:    rgb_d = {8'd0, full_q, t_val};
      3'd3:    rgb_d = {8'd0, q_val, full_q};
      3'd4:    rgb_d = {t_val, 8'd0, full_q};
      default: rgb_d = {full_q, 8'd0, q_val};
    endcase
  end

  always_ff @(posedge clk_i) begin
    sector1_q <= sector_d;
    rem_q     <= rem_d;
    sector2_q <= sector1_q;
    prod_t_q  <= prod_t_d;
    prod_q_q  <= prod_q_d;
    full_q    <= levels_i;
    rgb_q     <= rgb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  assign done_o = vld_q[2];
  assign rgb_o  = rgb_q;

endmodule

### rtl/rgb_led_matrix_pwm_scanner.sv
// ----------------------------------------------------------------------------
// rgb_led_matrix_pwm_scanner: row-scanned software PWM for an RGB LED matrix
// An RGB write passes the write state, a hue write waits for the converter, a
// bank swap ends on acceptance, and a scan step reads all row columns first.
// Throughput: one transaction at a time; a scan step is bound by the
// single-port pixel store, which returns one column of the row per cycle.
// Reset: asynchronous, active low; the pixel store reads as all zero, bank 0
// is shown, the PWM cycle and scan row start at zero, levels reset to 255.
// ----------------------------------------------------------------------------
module rgb_led_matrix_pwm_scanner
  import rlm_pkg::*;
#(
  parameter int unsigned ROW_COUNT    = RowCountDef,
  parameter int unsigned COLUMN_COUNT = ColCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration: brightness_levels.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: row_index[2:0], column_index[5:3], red_level[13:6],
  // green_level[21:14], blue_level[29:22], hue_degrees[38:30], zero pad[39].
  input  logic [39:0] s_axis_tdata,
  // tuser from bit 0: mode[1:0].
  input  logic [1:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: blue_sink_mask[7:0], green_sink_mask[15:8],
  // red_sink_mask[23:16], row_enable[31:24].
  output logic [31:0] m_axis_tdata,
  // tlast carries frame_done.
  output logic        m_axis_tlast
);

  localparam logic [IdxW-1:0] LastRow = IdxW'(ROW_COUNT - 1);
  localparam logic [IdxW-1:0] LastCol = IdxW'(COLUMN_COUNT - 1);

  // Sequencer state codes.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWrite = 3'd1;
  localparam logic [2:0] StHue   = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StLast  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  // Input fields.
  rlm_mode_e         in_mode;
  logic [IdxW-1:0]   in_row, in_col;
  logic [LevelW-1:0] in_red, in_green, in_blue;
  logic [HueW-1:0]   in_hue;
  logic              in_fire, in_range;

  assign in_mode  = rlm_mode_e'(s_axis_tuser);
  assign in_row   = s_axis_tdata[2:0];
  assign in_col   = s_axis_tdata[5:3];
  assign in_red   = s_axis_tdata[13:6];
  assign in_green = s_axis_tdata[21:14];
  assign in_blue  = s_axis_tdata[29:22];
  assign in_hue   = s_axis_tdata[38:30];

  logic [2:0]        state_q, state_d;
  logic              bank_q, bank_d;
  logic [LevelW-1:0] pwm_q, pwm_d;
  logic [IdxW-1:0]   row_q, row_d;
  logic [LevelW-1:0] levels_q;
  logic [IdxW-1:0]   col_q, col_d;
  logic [IdxW-1:0]   rd_col_q;
  logic              rd_pend_q;
  logic              blank_q, blank_d;
  logic [7:0]        rmask_q, rmask_d, gmask_q, gmask_d, bmask_q, bmask_d;
  logic [AddrW-1:0]  wr_addr_q, wr_addr_d;
  logic [PixW-1:0]   wr_rgb_q, wr_rgb_d;
  logic              out_vld_q, out_vld_d;
  logic [31:0]       out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  rlm_store_req_t    store_req;
  logic [PixW-1:0]   store_rdata;
  logic              hue_start, hue_done;
  logic [PixW-1:0]   hue_rgb;
  logic              out_free;

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // Pixel writes outside the configured matrix are dropped.
  assign in_range      = ({1'b0, in_row} < 4'(ROW_COUNT)) &&
                         ({1'b0, in_col} < 4'(COLUMN_COUNT));
  assign hue_start     = in_fire && (in_mode == MODE_HUE) && in_range;
  assign out_free      = !out_vld_q || m_axis_tready;

  rlm_pixel_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  rlm_hue_conv u_hue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hue_start),
    .hue_i    (in_hue),
    .levels_i (levels_q),
    .done_o   (hue_done),
    .rgb_o    (hue_rgb)
  );

  always_comb begin
    state_d    = state_q;
    bank_d     = bank_q;
    pwm_d      = pwm_q;
    row_d      = row_q;
    col_d      = col_q;
    blank_d    = blank_q;
    rmask_d    = rmask_q;
    gmask_d    = gmask_q;
    bmask_d    = bmask_q;
    wr_addr_d  = wr_addr_q;
    wr_rgb_d   = wr_rgb_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_last_d = out_last_q;

    store_req       = '0;
    store_req.addr  = {bank_q, row_q, col_q};
    store_req.wdata = wr_rgb_q;

    // Fold the column returned by the store into the sink masks. A bit is
    // cleared, lighting the LED, while the PWM cycle is below its level.
    if (rd_pend_q) begin
      if (pwm_q < store_rdata[23:16]) rmask_d[rd_col_q] = 1'b0;
      if (pwm_q < store_rdata[15:8])  gmask_d[rd_col_q] = 1'b0;
      if (pwm_q < store_rdata[7:0])   bmask_d[rd_col_q] = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          wr_addr_d = {bank_q, in_row, in_col};
          case (in_mode)
            MODE_RGB: begin
              wr_rgb_d = {in_red, in_green, in_blue};
              if (in_range) state_d = StWrite;
            end
            MODE_HUE: begin
              if (in_range) state_d = StHue;
            end
            MODE_SWAP: begin
              bank_d = !bank_q;
            end
            default: begin
              rmask_d = '1;
              gmask_d = '1;
              bmask_d = '1;
              col_d   = '0;
              // Once every PWM cycle of the frame has run, or the level
              // count dropped below the current cycle, end the frame.
              if (pwm_q >= levels_q) begin
                blank_d = 1'b1;
                state_d = StOut;
              end else begin
                blank_d = 1'b0;
                state_d = StRead;
              end
            end
          endcase
        end
      end
      StWrite: begin
        store_req.we   = 1'b1;
        store_req.addr = wr_addr_q;
        state_d        = StIdle;
      end
      StHue: begin
        if (hue_done) begin
          store_req.we    = 1'b1;
          store_req.addr  = wr_addr_q;
          store_req.wdata = hue_rgb;
          state_d         = StIdle;
        end
      end
      StRead: begin
        store_req.re = 1'b1;
        col_d        = col_q + 1'b1;
        if (col_q == LastCol) state_d = StLast;
      end
      StLast: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          state_d   = StIdle;
          if (blank_q) begin
            out_data_d = {8'h00, 8'hFF, 8'hFF, 8'hFF};
            out_last_d = 1'b1;
            pwm_d      = '0;
            row_d      = '0;
          end else begin
            out_data_d = {8'b1 << row_q, rmask_q, gmask_q, bmask_q};
            out_last_d = 1'b0;
            if (row_q == LastRow) begin
              row_d = '0;
              // The cycle count sticks at its top value instead of wrapping.
              pwm_d = (pwm_q == 8'hFF) ? pwm_q : pwm_q + 1'b1;
            end else begin
              row_d = row_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bank_q    <= 1'b0;
      pwm_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      levels_q  <= LevelsReset;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bank_q    <= bank_d;
      pwm_q     <= pwm_d;
      row_q     <= row_d;
      col_q     <= col_d;
      rd_pend_q <= (state_q == StRead);
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) levels_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_col_q   <= col_q;
    blank_q    <= blank_d;
    rmask_q    <= rmask_d;
    gmask_q    <= gmask_d;
    bmask_q    <= bmask_d;
    wr_addr_q  <= wr_addr_d;
    wr_rgb_q   <= wr_rgb_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### rtl/rlm_checker.sv
// ----------------------------------------------------------------------------
// rlm_checker: port-level checks for the LED matrix scanner
// Watches the result stream for well-formed scan and blanking words, stall hold and reset.
// ----------------------------------------------------------------------------
module rlm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result must hold its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The blanking word turns every sink off and every row off.
  a_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 32'h00FF_FFFF)
    else $error("blanking word is not all off");

  // A scan word drives exactly one row.
  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> $onehot(m_axis_tdata[31:24]))
    else $error("scan word row enable is not one-hot");

  // No result is offered in the cycle that follows a clock edge in reset.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind rgb_led_matrix_pwm_scanner rlm_checker u_rlm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
